// File: rtl/core/bca_pkg.sv
// Package for the bitmap cell allocator: sizes, status and state types,
// and the reset pattern of the in-use bitmap. Depends on nothing.
`default_nettype none

package bca_pkg;

  localparam int CELLS           = 510;
  localparam int MAX_SMALL_BYTES = 49152;

  localparam int CELL_SHIFT   = 7;
  localparam int CELL_ROUND   = 'h7F;
  localparam int HEADER_BYTES = 'h100;
  localparam int HEADER_CELLS = 2;

  localparam int BITMAP_BYTES = (CELLS + HEADER_CELLS + 7) / 8;
  localparam int BYTE_AW      = $clog2(BITMAP_BYTES);
  localparam int CIDX_W       = BYTE_AW + 3;
  localparam int LAST_BYTE    = BITMAP_BYTES - 1;
  localparam int MAX_NEED     = (MAX_SMALL_BYTES + CELL_ROUND) >> CELL_SHIFT;
  localparam int NEED_W       = $clog2(MAX_NEED + 1);
  localparam int CNT_W        = 9;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_BAD,
    RES_SHORT,
    RES_MISS,
    RES_ALLOC,
    RES_FREE
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_FIN
  } state_e;

  // Cells below HEADER_CELLS and cells past the end of the page read as used.
  function automatic logic [7:0] rst_byte(input logic [BYTE_AW-1:0] a);
    logic [CIDX_W-1:0] c;
    logic [7:0]        b;
    for (int j = 0; j < 8; j++) begin
      c    = {a, 3'(j)};
      b[j] = (c < CIDX_W'(HEADER_CELLS)) || (c >= CIDX_W'(CELLS));
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bca_req_if.sv
// Request channel of the bitmap cell allocator: valid, ready and payload.
// Depends on nothing.
`default_nettype none

interface bca_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] byte_size;
  logic [15:0] address_offset;

  modport source(output valid, output req_type, output byte_size, output address_offset,
                 input ready);
  modport sink(input valid, input req_type, input byte_size, input address_offset,
               output ready);
endinterface

`default_nettype wire

// File: rtl/core/bca_rsp_if.sv
// Response channel of the bitmap cell allocator: valid, ready and payload.
// Depends on nothing.
`default_nettype none

interface bca_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] block_offset;
  logic [8:0]  free_cells;

  modport source(output valid, output status, output block_offset, output free_cells,
                 input ready);
  modport sink(input valid, input status, input block_offset, input free_cells,
               output ready);
endinterface

`default_nettype wire

// File: rtl/core/bitmap_cell_allocator.sv
// Bitmap cell allocator: first-fit allocation and release of 128-byte cells in one page.
// Depends on bca_pkg, bca_req_if and bca_rsp_if.
//
//   channel  direction  payload
//   req_i    in         req_type, byte_size, address_offset
//   rsp_o    out        status, block_offset, free_cells
//
// A bad or short request passes from idle straight to the finish state and its response.
// An allocate scans the bitmap memory 8 cells a cycle, up to all 64 bytes, then marks
// the run with a read and a write state per bitmap byte it touches; a free only marks.
// Reset clears per-byte valid bits at once, so no clearing pass is needed.
// The response register holds a result while the next request is taken;
// a finished request waits in its last state until that register is free.
`default_nettype none

module bitmap_cell_allocator (
  input  wire        clk_i,
  input  wire        rst_ni,
  bca_req_if.sink    req_i,
  bca_rsp_if.source  rsp_o
);
  import bca_pkg::*;

  state_e                state_q, state_d;
  res_e                  res_q, res_d;
  logic [NEED_W-1:0]     need_q, need_d;
  logic [CIDX_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [CIDX_W-1:0]     start_q, start_d;
  logic [NEED_W-1:0]     run_q, run_d;
  logic [BYTE_AW-1:0]    eb_q, eb_d, mb_q, mb_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ov_q, ov_d;
  status_e               st_q, st_d;
  logic [15:0]           off_q, off_d;

  logic [7:0]            mem_q [BITMAP_BYTES];
  logic [BITMAP_BYTES-1:0] vld_q;
  logic [7:0]            rdata_q;
  logic [BYTE_AW-1:0]    rd_addr;
  logic                  we;
  logic [7:0]            wdata;

  logic [NEED_W-1:0]     need_c;
  logic [16:0]           size_sum;
  logic [15:0]           addr_diff;
  logic [CIDX_W-1:0]     fidx;
  logic [CIDX_W:0]       hi_sum;
  logic [CIDX_W-1:0]     hi_free;
  logic                  size_bad;

  logic [NEED_W-1:0]     run_v;
  logic [CIDX_W-1:0]     start_v;
  logic                  hit_v;
  logic [7:0]            mask;
  logic [CIDX_W:0]       alloc_hi;
  logic [CNT_W:0]        free_sum;
  logic [CIDX_W+CELL_SHIFT:0] off_full;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = st_q;
  assign rsp_o.block_offset = off_q;
  assign rsp_o.free_cells  = cnt_q;

  assign size_sum  = {1'b0, req_i.byte_size} + 17'(CELL_ROUND);
  assign need_c    = NEED_W'(size_sum >> CELL_SHIFT);
  assign size_bad  = (req_i.byte_size == 16'd0) || (req_i.byte_size > 16'(MAX_SMALL_BYTES));
  assign addr_diff = req_i.address_offset - 16'(HEADER_BYTES);
  assign fidx      = CIDX_W'(addr_diff >> CELL_SHIFT);
  assign hi_sum    = {1'b0, fidx} + (CIDX_W+1)'(need_c) - 1'b1;
  assign hi_free   = (hi_sum >= (CIDX_W+1)'(CELLS)) ? CIDX_W'(CELLS - 1)
                                                    : hi_sum[CIDX_W-1:0];

  always_comb begin
    logic [CIDX_W-1:0] c;
    run_v   = run_q;
    start_v = start_q;
    hit_v   = 1'b0;
    for (int j = 0; j < 8; j++) begin
      c = {eb_q, 3'(j)};
      if (!hit_v) begin
        if (rdata_q[j] || (c >= CIDX_W'(CELLS))) begin
          run_v   = '0;
          start_v = CIDX_W'(c + 1'b1);
        end else begin
          run_v = NEED_W'(run_v + 1'b1);
          if (run_v >= need_q) begin
            hit_v = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [CIDX_W-1:0] c;
    for (int j = 0; j < 8; j++) begin
      c       = {mb_q, 3'(j)};
      mask[j] = (c >= lo_q) && (c <= hi_q);
    end
  end

  assign alloc_hi = {1'b0, start_v} + (CIDX_W+1)'(need_q) - 1'b1;
  assign free_sum = {1'b0, cnt_q} + (CNT_W+1)'(need_q);
  assign off_full = ({1'b0, lo_q} + (CIDX_W+1)'(HEADER_CELLS)) << CELL_SHIFT;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    need_d  = need_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    start_d = start_q;
    run_d   = run_q;
    eb_d    = eb_q;
    mb_d    = mb_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    off_d   = off_q;
    ov_d    = ov_q && !rsp_o.ready;
    rd_addr = mb_q;
    we      = 1'b0;
    wdata   = rdata_q;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = '0;
        if (req_i.valid) begin
          need_d = need_c;
          if (size_bad) begin
            res_d   = RES_BAD;
            state_d = S_FIN;
          end else if (req_i.req_type) begin
            if (req_i.address_offset < 16'(HEADER_BYTES)) begin
              res_d   = RES_BAD;
              state_d = S_FIN;
            end else begin
              res_d   = RES_FREE;
              lo_d    = fidx;
              hi_d    = hi_free;
              mb_d    = fidx[CIDX_W-1:3];
              state_d = S_MARK_RD;
            end
          end else if (cnt_q < CNT_W'(need_c)) begin
            res_d   = RES_SHORT;
            state_d = S_FIN;
          end else begin
            run_d   = '0;
            start_d = '0;
            eb_d    = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = BYTE_AW'(eb_q + 1'b1);
        run_d   = run_v;
        start_d = start_v;
        if (hit_v) begin
          res_d   = RES_ALLOC;
          lo_d    = start_v;
          hi_d    = alloc_hi[CIDX_W-1:0];
          mb_d    = start_v[CIDX_W-1:3];
          state_d = S_MARK_RD;
        end else if (eb_q == BYTE_AW'(LAST_BYTE)) begin
          res_d   = RES_MISS;
          state_d = S_FIN;
        end else begin
          eb_d = BYTE_AW'(eb_q + 1'b1);
        end
      end
      S_MARK_RD: begin
        rd_addr = mb_q;
        state_d = S_MARK_WR;
      end
      S_MARK_WR: begin
        we    = 1'b1;
        wdata = (res_q == RES_ALLOC) ? (rdata_q | mask) : (rdata_q & ~mask);
        if (mb_q == hi_q[CIDX_W-1:3]) begin
          state_d = S_FIN;
        end else begin
          mb_d    = BYTE_AW'(mb_q + 1'b1);
          state_d = S_MARK_RD;
        end
      end
      S_FIN: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          off_d   = '0;
          state_d = S_IDLE;
          case (res_q)
            RES_BAD: begin
              st_d = ST_BAD;
            end
            RES_SHORT: begin
              st_d = ST_NOSPACE;
            end
            RES_MISS: begin
              st_d  = ST_NOSPACE;
              cnt_d = CNT_W'(need_q - 1'b1);
            end
            RES_ALLOC: begin
              st_d  = ST_OK;
              cnt_d = CNT_W'(cnt_q - CNT_W'(need_q));
              off_d = off_full[15:0];
            end
            default: begin
              st_d  = ST_OK;
              cnt_d = (free_sum > (CNT_W+1)'(CELLS)) ? CNT_W'(CELLS)
                                                     : free_sum[CNT_W-1:0];
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= CNT_W'(CELLS);
      ov_q    <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (we) begin
        vld_q[mb_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    need_q  <= need_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    start_q <= start_d;
    run_q   <= run_d;
    eb_q    <= eb_d;
    mb_q    <= mb_d;
    st_q    <= st_d;
    off_q   <= off_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[mb_q] <= wdata;
    end
    rdata_q <= vld_q[rd_addr] ? mem_q[rd_addr] : rst_byte(rd_addr);
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CELLS))
    else $error("free-cell counter above the cell count");

  a_tail_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (hi_q < CIDX_W'(CELLS)))
    else $error("bitmap write reaches cells past the end of the page");

  a_fail_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.block_offset == 16'd0))
    else $error("failed request carries a block offset");

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (state_q != S_IDLE))
    else $error("scan left without marking or finishing");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && (!ov_q || rsp_o.ready)) |=> rsp_o.valid)
    else $error("finished request did not reach the response register");

endmodule

`default_nettype wire
